[rtl/ecr_pkg.sv]
// Shared types and constants for the entity/component registry.
// No dependencies; used by every module of the block but ecr_ram.
package ecr_pkg;

    localparam int N_ENT   = 64;
    localparam int N_COMP  = 8;
    localparam int ENT_W   = 6;
    localparam int COMP_W  = 3;
    localparam int CNT_W   = 7;
    localparam int SIG_W   = 8;
    localparam int SET_AW  = COMP_W + ENT_W;
    localparam int SET_D   = N_ENT * N_COMP;
    localparam int SOE_W   = ENT_W + 1;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_ASSOC    = 2'd2,
        OP_UNASSOC  = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic look;
        logic cr_id;
        logic cr_sig;
        logic assoc;
        logic chk;
        logic mv;
        logic next_comp;
        logic clr;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic clr_last;
        logic can_create;
        logic can_free;
        logic hit;
        logic move;
        logic last_comp;
    } t_dp_stat;

endpackage

[rtl/ecr_ram.sv]
// Generic single write, single read port RAM with registered read data.
// No dependencies.
module ecr_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ecr_ctrl.sv]
// Sequencer for the registry: clearing sweep, then one request at a time.
// Depends on ecr_pkg.
module ecr_ctrl
    import ecr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy,
    output logic     o_valid
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_CR_ID, S_CR_SIG, S_ASSOC, S_CHK, S_MV
    } t_state;

    // S_RD folded into S_CHK entry by re-reading: a separate flag, r_rd, marks the read
    typedef enum logic {RD_NO, RD_YES} t_rd;

    t_state r_state, n_state;
    t_rd    r_rd;
    logic   n_rd;
    logic   n_valid;
    logic   r_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        n_rd    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                unique case (i_stat.op)
                    OP_CREATE: begin
                        if (i_stat.can_create) n_state = S_CR_ID;
                        else begin
                            n_state = S_IDLE;
                            n_valid = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.can_free) n_state = S_CHK;
                        else begin
                            n_state = S_IDLE;
                            n_valid = 1'b1;
                        end
                    end
                    OP_ASSOC:   n_state = S_ASSOC;
                    OP_UNASSOC: n_state = S_CHK;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_CR_ID: begin
                o_cmd.cr_id = 1'b1;
                n_state     = S_CR_SIG;
            end
            S_CR_SIG: begin
                o_cmd.cr_sig = 1'b1;
                n_state      = S_IDLE;
                n_valid      = 1'b1;
            end
            S_ASSOC: begin
                o_cmd.assoc = 1'b1;
                n_state     = S_IDLE;
                n_valid     = 1'b1;
            end
            S_CHK: begin
                if (r_rd == RD_YES) begin
                    // read of the next component's entry is in flight
                    n_state = S_CHK;
                end else begin
                    o_cmd.chk = 1'b1;
                    if (i_stat.hit && i_stat.move) begin
                        n_state = S_MV;
                    end else if (i_stat.op == OP_REMOVE && !i_stat.last_comp) begin
                        o_cmd.next_comp = 1'b1;
                        n_rd            = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                    end
                end
            end
            S_MV: begin
                o_cmd.mv = 1'b1;
                if (i_stat.op == OP_REMOVE && !i_stat.last_comp) begin
                    o_cmd.next_comp = 1'b1;
                    n_state         = S_CHK;
                    n_rd            = 1'b1;
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rd    <= RD_NO;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd ? RD_YES : RD_NO;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

[rtl/ecr_dp.sv]
// Datapath of the registry: free ring, signatures, sparse sets, counters, result.
// Depends on ecr_pkg and ecr_ram.
module ecr_dp
    import ecr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [1:0]        i_opcode,
    input  logic [ENT_W-1:0]  i_entity_id,
    input  logic [COMP_W-1:0] i_component,
    output t_dp_stat          o_stat,
    output logic              o_ok,
    output logic [ENT_W-1:0]  o_result_entity,
    output logic [SIG_W-1:0]  o_entity_signature,
    output logic [ENT_W-1:0]  o_dense_slot
);

    t_op               r_op;
    logic [ENT_W-1:0]  r_ent;
    logic [COMP_W-1:0] r_cidx;
    logic [ENT_W-1:0]  r_head, r_tail, r_slot;
    logic [CNT_W-1:0]  r_free_cnt, r_live;
    logic [CNT_W-1:0]  r_size [N_COMP];
    logic [N_ENT-1:0]  r_ring_v, r_sig_v;
    logic [SET_AW-1:0] r_clr;
    logic              r_ok;
    logic [ENT_W-1:0]  r_res_e, r_slot_o;
    logic [SIG_W-1:0]  r_sig_o;

    logic [ENT_W-1:0]  ring_rd, id_new;
    logic [SIG_W-1:0]  sig_rd, sig_old, bit_c;
    logic [SOE_W-1:0]  soe_rd;
    logic [ENT_W-1:0]  eos_rd;
    logic [CNT_W-1:0]  cur_size, cur_last;
    logic              can_add;

    logic              ring_we, sig_we, soe_we, eos_we;
    logic [ENT_W-1:0]  sig_waddr, sig_raddr;
    logic [SIG_W-1:0]  sig_wdata;
    logic [SET_AW-1:0] soe_waddr, eos_waddr;
    logic [SOE_W-1:0]  soe_wdata;
    logic [ENT_W-1:0]  eos_wdata;

    assign cur_size = r_size[r_cidx];
    assign cur_last = cur_size - 1'b1;
    assign sig_old  = r_sig_v[r_ent] ? sig_rd : '0;
    assign bit_c    = SIG_W'(1) << r_cidx;
    assign id_new   = r_ring_v[r_head] ? ring_rd : r_head;
    assign can_add  = !soe_rd[SOE_W-1] && (cur_size < CNT_W'(N_ENT));
    assign sig_raddr = i_cmd.cr_id ? id_new : r_ent;

    assign o_stat.op         = r_op;
    assign o_stat.clr_last   = (r_clr == SET_AW'(SET_D - 1));
    assign o_stat.can_create = (r_live < CNT_W'(N_ENT)) && (r_free_cnt != '0);
    assign o_stat.can_free   = (r_free_cnt < CNT_W'(N_ENT));
    assign o_stat.hit        = soe_rd[SOE_W-1] && (cur_size != '0);
    assign o_stat.move       = (soe_rd[ENT_W-1:0] != cur_last[ENT_W-1:0]);
    assign o_stat.last_comp  = (r_cidx == COMP_W'(N_COMP - 1));

    always_comb begin
        ring_we   = i_cmd.look && (r_op == OP_REMOVE) && o_stat.can_free;
        sig_we    = 1'b0;
        sig_waddr = r_ent;
        sig_wdata = '0;
        soe_we    = 1'b0;
        soe_waddr = {r_cidx, r_ent};
        soe_wdata = '0;
        eos_we    = 1'b0;
        eos_waddr = {r_cidx, cur_size[ENT_W-1:0]};
        eos_wdata = r_ent;
        if (i_cmd.clr) begin
            soe_we    = 1'b1;
            soe_waddr = r_clr;
        end
        if (i_cmd.look && r_op == OP_REMOVE) begin
            sig_we = 1'b1;
        end
        if (i_cmd.assoc && can_add) begin
            sig_we    = 1'b1;
            sig_wdata = sig_old | bit_c;
            soe_we    = 1'b1;
            soe_wdata = {1'b1, cur_size[ENT_W-1:0]};
            eos_we    = 1'b1;
        end
        if (i_cmd.chk && o_stat.hit) begin
            soe_we = 1'b1;
            if (r_op == OP_UNASSOC) begin
                sig_we    = 1'b1;
                sig_wdata = sig_old & ~bit_c;
            end
        end
        if (i_cmd.mv) begin
            // last dense entry moves into the vacated slot
            soe_we    = 1'b1;
            soe_waddr = {r_cidx, eos_rd};
            soe_wdata = {1'b1, r_slot};
            eos_we    = 1'b1;
            eos_waddr = {r_cidx, r_slot};
            eos_wdata = eos_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_free_cnt <= CNT_W'(N_ENT);
            r_live     <= '0;
            r_ring_v   <= '0;
            r_sig_v    <= '0;
            r_clr      <= '0;
            for (int i = 0; i < N_COMP; i++) begin
                r_size[i] <= '0;
            end
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (sig_we) r_sig_v[sig_waddr] <= 1'b1;
            if (ring_we) begin
                r_ring_v[r_tail] <= 1'b1;
                r_tail     <= (r_tail == ENT_W'(N_ENT - 1)) ? '0 : r_tail + 1'b1;
                r_free_cnt <= r_free_cnt + 1'b1;
                if (r_live != '0) r_live <= r_live - 1'b1;
            end
            if (i_cmd.cr_id) begin
                r_head     <= (r_head == ENT_W'(N_ENT - 1)) ? '0 : r_head + 1'b1;
                r_free_cnt <= r_free_cnt - 1'b1;
                r_live     <= r_live + 1'b1;
            end
            if (i_cmd.assoc && can_add) r_size[r_cidx] <= cur_size + 1'b1;
            if (i_cmd.chk && o_stat.hit) r_size[r_cidx] <= cur_last;
        end
    end

    // request context and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_opcode);
            r_ent    <= i_entity_id;
            r_cidx   <= (t_op'(i_opcode) == OP_REMOVE) ? '0 : i_component;
            r_ok     <= 1'b0;
            r_res_e  <= (t_op'(i_opcode) == OP_CREATE) ? '0 : i_entity_id;
            r_sig_o  <= '0;
            r_slot_o <= '0;
        end
        if (ring_we) r_ok <= 1'b1;
        if (i_cmd.cr_id) begin
            r_res_e <= id_new;
            r_ok    <= 1'b1;
        end
        if (i_cmd.cr_sig) r_sig_o <= r_sig_v[r_res_e] ? sig_rd : '0;
        if (i_cmd.assoc) begin
            if (can_add) begin
                r_sig_o  <= sig_old | bit_c;
                r_slot_o <= cur_size[ENT_W-1:0];
                r_ok     <= 1'b1;
            end else begin
                r_sig_o <= sig_old;
            end
        end
        if (i_cmd.chk) begin
            if (o_stat.hit) r_slot <= soe_rd[ENT_W-1:0];
            if (r_op == OP_UNASSOC) begin
                if (o_stat.hit) begin
                    r_sig_o  <= sig_old & ~bit_c;
                    r_slot_o <= soe_rd[ENT_W-1:0];
                    r_ok     <= 1'b1;
                end else begin
                    r_sig_o <= sig_old;
                end
            end
        end
        if (i_cmd.next_comp) r_cidx <= r_cidx + 1'b1;
    end

    ecr_ram #(.W(ENT_W), .D(N_ENT)) u_ring (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(r_tail), .i_wdata(r_ent),
        .i_raddr(r_head), .o_rdata(ring_rd)
    );

    ecr_ram #(.W(SIG_W), .D(N_ENT)) u_sig (
        .i_clk(i_clk), .i_we(sig_we), .i_waddr(sig_waddr), .i_wdata(sig_wdata),
        .i_raddr(sig_raddr), .o_rdata(sig_rd)
    );

    ecr_ram #(.W(SOE_W), .D(SET_D)) u_soe (
        .i_clk(i_clk), .i_we(soe_we), .i_waddr(soe_waddr), .i_wdata(soe_wdata),
        .i_raddr({r_cidx, r_ent}), .o_rdata(soe_rd)
    );

    ecr_ram #(.W(ENT_W), .D(SET_D)) u_eos (
        .i_clk(i_clk), .i_we(eos_we), .i_waddr(eos_waddr), .i_wdata(eos_wdata),
        .i_raddr({r_cidx, cur_last[ENT_W-1:0]}), .o_rdata(eos_rd)
    );

    assign o_ok               = r_ok;
    assign o_result_entity    = r_res_e;
    assign o_entity_signature = r_sig_o;
    assign o_dense_slot       = r_slot_o;

endmodule

[rtl/entity_component_registry_core.sv]
// Entity/component registry with sparse-set component storage.
// A request (opcode, entity, component) is taken when start is high and busy low.
// One result per request: o_ok, o_result_entity, o_entity_signature, o_dense_slot,
// shown for exactly one cycle with o_valid high; the receiver cannot stall, so the
// result must be taken in that cycle. busy is low again in the o_valid cycle.
// Sequence from accept to o_valid (every memory has a registered read port):
//   create does a ring read, then a signature read of the new ID; a failed create
//   ends after the lookup; unassociate takes an extra step when the last dense entry
//   moves; remove ends at the lookup on a full ring, else walks all component sets.
// The next request is taken in the o_valid cycle; the remove walk over all component
// sets, one set at a time through the slot map, sets the worst case.
// After reset the slot map is swept to "absent", one entry a cycle, with busy high.
// Free ring and signatures need no sweep.
// Depends on ecr_pkg, ecr_ctrl, ecr_dp.
module entity_component_registry_core
    import ecr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic [ENT_W-1:0]  i_entity_id,
    input  logic [COMP_W-1:0] i_component,
    output logic              o_valid,
    output logic              o_ok,
    output logic [ENT_W-1:0]  o_result_entity,
    output logic [SIG_W-1:0]  o_entity_signature,
    output logic [ENT_W-1:0]  o_dense_slot
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ecr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_stat(stat),
        .o_cmd(cmd), .busy(busy), .o_valid(o_valid)
    );

    ecr_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_opcode(i_opcode), .i_entity_id(i_entity_id), .i_component(i_component),
        .o_stat(stat), .o_ok(o_ok), .o_result_entity(o_result_entity),
        .o_entity_signature(o_entity_signature), .o_dense_slot(o_dense_slot)
    );

endmodule

[rtl/ecr_checker.sv]
// Port-level checks for the registry core, attached by bind.
// Depends on ecr_pkg and entity_component_registry_core.
module ecr_checker
    import ecr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        i_opcode,
    input logic [ENT_W-1:0]  i_entity_id,
    input logic [COMP_W-1:0] i_component,
    input logic              o_valid,
    input logic              o_ok,
    input logic [ENT_W-1:0]  o_result_entity,
    input logic [SIG_W-1:0]  o_entity_signature,
    input logic [ENT_W-1:0]  o_dense_slot
);

    // an accepted request keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request accepted but not busy");

    // results never come back to back
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // a failed request never reports a dense slot
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_dense_slot == '0) else $error("slot on failure");

    // no result without a request having been taken
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without request");

endmodule

bind entity_component_registry_core ecr_checker u_ecr_checker (.*);
